// File: design/assert_macros.svh
// Assertion macros shared by the colour vote RTL.
// IMP checks an implication in the same cycle, NXT in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPCV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpcv assertion failed");
`define CPCV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpcv assertion failed");
`else
`define CPCV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPCV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/cpcv_pkg.sv
`timescale 1ns / 1ps

package cpcv_pkg;

    // Field and register widths
    localparam int LEVEL_W    = 8;
    localparam int TALLY_W    = 13;
    localparam int ENEMY_W    = 2;
    localparam int DIFF_W     = 8;
    localparam int PURPLE_W   = 12;
    localparam int VOTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Defaults for top-level parameters
    localparam int DEF_MAX_POINTS  = 4096;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENEMY_COLOR,
        CFG_DIFF_RATIO,
        CFG_PURPLE_RATIO,
        CFG_VOTE_FRACTION
    } cfg_index_t;

    // Register reset values
    localparam logic [ENEMY_W-1:0]  ENEMY_RESET  = 2'd0;
    localparam logic [DIFF_W-1:0]   DIFF_RESET   = 8'd77;
    localparam logic [PURPLE_W-1:0] PURPLE_RESET = 12'd384;
    localparam logic [VOTE_W-1:0]   VOTE_RESET   = 8'd128;

    // Target colour codes; any other code votes on purple alone
    localparam logic [ENEMY_W-1:0] ENEMY_BLUE = 2'd0;
    localparam logic [ENEMY_W-1:0] ENEMY_RED  = 2'd1;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_BLUE,
        CLS_RED,
        CLS_PURPLE
    } pixel_class_t;

    // One classified point travelling from front to back
    typedef struct packed {
        pixel_class_t cls;
        logic         last;
    } point_token_t;

    // Per-contour counts
    typedef struct packed {
        logic [TALLY_W-1:0] blue;
        logic [TALLY_W-1:0] red;
        logic [TALLY_W-1:0] purple;
        logic [TALLY_W-1:0] total;
    } tally_set_t;

endpackage

// File: design/cpcv_classify.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpcv_classify (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cpcv_pkg::LEVEL_W-1:0]   blue_level,
    input  logic [cpcv_pkg::LEVEL_W-1:0]   green_level,
    input  logic [cpcv_pkg::LEVEL_W-1:0]   red_level,
    input  logic                           last_point,
    input  logic [cpcv_pkg::DIFF_W-1:0]    diff_ratio,
    input  logic [cpcv_pkg::PURPLE_W-1:0]  purple_ratio,
    output logic                           tok_valid,
    input  logic                           tok_ready,
    output cpcv_pkg::point_token_t         tok
);
    import cpcv_pkg::*;

    localparam int SumW   = LEVEL_W + 1;
    localparam int LimW   = SumW + DIFF_W;
    localparam int ProdW  = LEVEL_W + PURPLE_W;

    logic [SumW-1:0]    sum;
    logic [LimW-1:0]    limit;
    logic [LimW-1:0]    br_scaled;
    logic [LimW-1:0]    rb_scaled;
    logic [ProdW-1:0]   b_times_p;
    logic [ProdW-1:0]   r_times_p;
    logic [ProdW-1:0]   b_shift;
    logic [ProdW-1:0]   r_shift;
    logic               is_blue;
    logic               is_red;
    logic               is_purple;
    point_token_t       tok_next;
    point_token_t       tok_reg;
    logic               tok_valid_reg;
    logic               tok_valid_next;
    logic               load;

    // Colour tests; every ratio is compared by cross-multiplication
    always_comb
    begin
        sum       = SumW'(blue_level) + SumW'(red_level);
        limit     = LimW'(sum) * LimW'(diff_ratio);
        br_scaled = LimW'({LEVEL_W'(blue_level - red_level), 8'd0});
        rb_scaled = LimW'({LEVEL_W'(red_level - blue_level), 8'd0});
        b_times_p = ProdW'(blue_level) * ProdW'(purple_ratio);
        r_times_p = ProdW'(red_level) * ProdW'(purple_ratio);
        b_shift   = ProdW'({blue_level, 8'd0});
        r_shift   = ProdW'({red_level, 8'd0});
        is_blue   = (blue_level > red_level) && (br_scaled > limit);
        is_red    = (red_level > blue_level) && (rb_scaled > limit);
        is_purple = (b_times_p > r_shift) && (b_shift < r_times_p)
                    && (sum[SumW-1:1] > green_level);
    end

    // Pick the class in priority order
    always_comb
    begin
        tok_next.last = last_point;
        if (is_blue)
        begin
            tok_next.cls = CLS_BLUE;
        end
        else if (is_red)
        begin
            tok_next.cls = CLS_RED;
        end
        else if (is_purple)
        begin
            tok_next.cls = CLS_PURPLE;
        end
        else
        begin
            tok_next.cls = CLS_NONE;
        end
    end

    // Stage register: take a beat when empty or whenever the held one leaves
    assign in_ready = !tok_valid_reg || tok_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            tok_valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            tok_valid_next = 1'b0;
        end
        else
        begin
            tok_valid_next = tok_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

// File: design/cpcv_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpcv_queue #(
    parameter int DEPTH = cpcv_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  cpcv_pkg::point_token_t  push_tok,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output cpcv_pkg::point_token_t  pop_tok
);
    import cpcv_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);

    point_token_t       slot_reg [DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_next;
    logic [CntW-1:0]    count_reg;
    logic [CntW-1:0]    count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = slot_reg[rd_ptr_reg];

    // Advance pointers with explicit wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    `CPCV_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, count_reg <= FullCnt)

endmodule

// File: design/cpcv_tally.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpcv_tally #(
    parameter int MAX_POINTS = cpcv_pkg::DEF_MAX_POINTS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tok_valid,
    output logic                    tok_ready,
    input  cpcv_pkg::point_token_t  tok,
    output logic                    set_valid,
    input  logic                    set_ready,
    output cpcv_pkg::tally_set_t    set
);
    import cpcv_pkg::*;

    localparam int TallyMax = (1 << TALLY_W) - 1;
    localparam int CapInt   = (MAX_POINTS < TallyMax) ? MAX_POINTS : TallyMax;
    localparam logic [TALLY_W-1:0] TallyCap = TALLY_W'(CapInt);

    tally_set_t     tally_reg;
    tally_set_t     tally_next;
    tally_set_t     bumped;
    tally_set_t     set_reg;
    logic           set_valid_reg;
    logic           set_valid_next;
    logic           pop;
    logic           close;
    logic           class_le_total;

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] t);
        bump = (t < TallyCap) ? t + TALLY_W'(1) : TallyCap;
    endfunction

    // A closing beat may only leave when the count stage is free
    assign tok_ready = !tok.last || !set_valid_reg || set_ready;
    assign pop       = tok_valid && tok_ready;
    assign close     = pop && tok.last;

    // Saturating counts including the current point
    always_comb
    begin
        bumped        = tally_reg;
        bumped.total  = bump(tally_reg.total);
        case (tok.cls)
            CLS_BLUE:   bumped.blue   = bump(tally_reg.blue);
            CLS_RED:    bumped.red    = bump(tally_reg.red);
            CLS_PURPLE: bumped.purple = bump(tally_reg.purple);
            default:    bumped.blue   = tally_reg.blue;
        endcase
    end

    // Hold, advance, or clear at the end of a contour
    always_comb
    begin
        tally_next = tally_reg;
        if (close)
        begin
            tally_next = '0;
        end
        else if (pop)
        begin
            tally_next = bumped;
        end
    end

    always_comb
    begin
        if (close)
        begin
            set_valid_next = 1'b1;
        end
        else if (set_ready)
        begin
            set_valid_next = 1'b0;
        end
        else
        begin
            set_valid_next = set_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg     <= '0;
            set_valid_reg <= 1'b0;
        end
        else
        begin
            tally_reg     <= tally_next;
            set_valid_reg <= set_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            set_reg <= bumped;
        end
    end

    assign set_valid = set_valid_reg;
    assign set       = set_reg;

    // No class count runs ahead of the point count
    assign class_le_total = (tally_reg.blue <= tally_reg.total)
                            && (tally_reg.red <= tally_reg.total)
                            && (tally_reg.purple <= tally_reg.total);

    `CPCV_ASSERT_IMP(a_total_cap, clk, rst_n, 1'b1, tally_reg.total <= TallyCap)
    `CPCV_ASSERT_IMP(a_class_le_total, clk, rst_n, 1'b1, class_le_total)
    `CPCV_ASSERT_NXT(a_clear_on_close, clk, rst_n, close, tally_reg.total == '0)

endmodule

// File: design/cpcv_vote.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpcv_vote (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           set_valid,
    output logic                           set_ready,
    input  cpcv_pkg::tally_set_t           set,
    input  logic [cpcv_pkg::ENEMY_W-1:0]   enemy_color,
    input  logic [cpcv_pkg::VOTE_W-1:0]    vote_fraction,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           accepted,
    output logic [cpcv_pkg::TALLY_W-1:0]   blue_points,
    output logic [cpcv_pkg::TALLY_W-1:0]   red_points,
    output logic [cpcv_pkg::TALLY_W-1:0]   purple_points,
    output logic [cpcv_pkg::TALLY_W-1:0]   total_points
);
    import cpcv_pkg::*;

    localparam int NeedW = TALLY_W + VOTE_W;
    localparam int WideW = NeedW + 4;

    logic [NeedW-1:0]   need;
    logic [WideW-1:0]   need_nine;
    logic [WideW-1:0]   purple_scaled;
    logic [NeedW-1:0]   blue_scaled;
    logic [NeedW-1:0]   red_scaled;
    logic               accepted_next;
    logic               accepted_reg;
    tally_set_t         out_set_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               load;

    // Vote: target share against F*n, purple share against 0.9*F*n
    always_comb
    begin
        need          = NeedW'(vote_fraction) * NeedW'(set.total);
        need_nine     = WideW'(need) + (WideW'(need) << 3);
        purple_scaled = (WideW'(set.purple) << 11) + (WideW'(set.purple) << 9);
        blue_scaled   = NeedW'({set.blue, 8'd0});
        red_scaled    = NeedW'({set.red, 8'd0});
        accepted_next = ((enemy_color == ENEMY_BLUE) && (blue_scaled > need))
                        || ((enemy_color == ENEMY_RED) && (red_scaled > need))
                        || (purple_scaled > need_nine);
    end

    // Output register: refill when empty or when the beat is taken
    assign set_ready = !out_valid_reg || out_ready;
    assign load      = set_valid && set_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            accepted_reg <= accepted_next;
            out_set_reg  <= set;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign blue_points   = out_set_reg.blue;
    assign red_points    = out_set_reg.red;
    assign purple_points = out_set_reg.purple;
    assign total_points  = out_set_reg.total;

    `CPCV_ASSERT_IMP(a_result_nonempty, clk, rst_n, out_valid_reg, out_set_reg.total != '0)

endmodule

// File: design/contour_pixel_color_vote_core.sv
`timescale 1ns / 1ps

// Colour vote over one contour. Each beat carries the BGR pixel under one
// contour point; the beat with last_point set closes the contour and yields
// one result beat with the saturating blue, red, purple and total counts and
// the accept flag, after which the counts restart from zero. Points that are
// not last yield nothing. The block takes one point per clock cycle while no
// stage downstream stalls. A result passes from the classifier register
// through the queue and the closed-count register to the result register.
// A small queue between the classifier and the counters lets either side
// stall alone. Configuration writes take effect at once and are meant for
// idle periods only.
module contour_pixel_color_vote_core #(
    parameter int MAX_POINTS  = cpcv_pkg::DEF_MAX_POINTS,
    parameter int QUEUE_DEPTH = cpcv_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cpcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpcv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cpcv_pkg::LEVEL_W-1:0]     blue_level,
    input  logic [cpcv_pkg::LEVEL_W-1:0]     green_level,
    input  logic [cpcv_pkg::LEVEL_W-1:0]     red_level,
    input  logic                             last_point,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             accepted,
    output logic [cpcv_pkg::TALLY_W-1:0]     blue_points,
    output logic [cpcv_pkg::TALLY_W-1:0]     red_points,
    output logic [cpcv_pkg::TALLY_W-1:0]     purple_points,
    output logic [cpcv_pkg::TALLY_W-1:0]     total_points
);
    import cpcv_pkg::*;

    logic [ENEMY_W-1:0]   enemy_reg;
    logic [ENEMY_W-1:0]   enemy_next;
    logic [DIFF_W-1:0]    diff_reg;
    logic [DIFF_W-1:0]    diff_next;
    logic [PURPLE_W-1:0]  purple_reg;
    logic [PURPLE_W-1:0]  purple_next;
    logic [VOTE_W-1:0]    vote_reg;
    logic [VOTE_W-1:0]    vote_next;

    logic           cls_valid;
    logic           cls_ready;
    point_token_t   cls_tok;
    logic           q_valid;
    logic           q_ready;
    point_token_t   q_tok;
    logic           set_valid;
    logic           set_ready;
    tally_set_t     set;

    // Configuration register writes
    always_comb
    begin
        enemy_next  = enemy_reg;
        diff_next   = diff_reg;
        purple_next = purple_reg;
        vote_next   = vote_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENEMY_COLOR:   enemy_next  = cfg_wdata[ENEMY_W-1:0];
                CFG_DIFF_RATIO:    diff_next   = cfg_wdata[DIFF_W-1:0];
                CFG_PURPLE_RATIO:  purple_next = cfg_wdata[PURPLE_W-1:0];
                CFG_VOTE_FRACTION: vote_next   = cfg_wdata[VOTE_W-1:0];
                default:           enemy_next  = enemy_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enemy_reg  <= ENEMY_RESET;
            diff_reg   <= DIFF_RESET;
            purple_reg <= PURPLE_RESET;
            vote_reg   <= VOTE_RESET;
        end
        else
        begin
            enemy_reg  <= enemy_next;
            diff_reg   <= diff_next;
            purple_reg <= purple_next;
            vote_reg   <= vote_next;
        end
    end

    // Front: classify each point
    cpcv_classify u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .blue_level   (blue_level),
        .green_level  (green_level),
        .red_level    (red_level),
        .last_point   (last_point),
        .diff_ratio   (diff_reg),
        .purple_ratio (purple_reg),
        .tok_valid    (cls_valid),
        .tok_ready    (cls_ready),
        .tok          (cls_tok)
    );

    // Decoupling queue
    cpcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_ready (cls_ready),
        .push_tok   (cls_tok),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_tok    (q_tok)
    );

    // Back: count and close contours
    cpcv_tally #(
        .MAX_POINTS (MAX_POINTS)
    ) u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .set_valid (set_valid),
        .set_ready (set_ready),
        .set       (set)
    );

    // Vote and result register
    cpcv_vote u_vote (
        .clk           (clk),
        .rst_n         (rst_n),
        .set_valid     (set_valid),
        .set_ready     (set_ready),
        .set           (set),
        .enemy_color   (enemy_reg),
        .vote_fraction (vote_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .blue_points   (blue_points),
        .red_points    (red_points),
        .purple_points (purple_points),
        .total_points  (total_points)
    );

endmodule

// File: dv/tb_contour_pixel_color_vote_core.sv
`timescale 1ns / 1ps

module tb_contour_pixel_color_vote_core;

    import cpcv_pkg::*;

    localparam int TALLY_CAP    = (DEF_MAX_POINTS < 8191) ? DEF_MAX_POINTS : 8191;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 85;

    // Target codes the package leaves unnamed: both vote on purple alone
    localparam logic [ENEMY_W-1:0] ENEMY_NEITHER = 2'd2;
    localparam logic [ENEMY_W-1:0] ENEMY_SPARE   = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
        logic               last;
    } pixel_beat_t;

    typedef struct packed {
        logic               accepted;
        logic [TALLY_W-1:0] blue;
        logic [TALLY_W-1:0] red;
        logic [TALLY_W-1:0] purple;
        logic [TALLY_W-1:0] total;
    } vote_t;

    typedef struct packed {
        pixel_beat_t px;
        logic        typed;
        vote_t       want;
    } directed_row_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam vote_t NO_VOTE = '0;

    // Directed rows under the reset settings; typed votes where they are obvious
    localparam int NUM_DIRECTED = 22;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // both channels zero: no class
        '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{1'b0, 13'd0, 13'd0, 13'd0, 13'd1}},
        '{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b1, '{1'b1, 13'd1, 13'd0, 13'd0, 13'd1}},
        '{'{8'd0,   8'd0,   8'd255, 1'b1}, 1'b1, '{1'b0, 13'd0, 13'd1, 13'd0, 13'd1}},
        // mean equal to green: not purple
        '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b0, 13'd0, 13'd0, 13'd0, 13'd1}},
        '{'{8'd128, 8'd0,   8'd128, 1'b1}, 1'b1, '{1'b1, 13'd0, 13'd0, 13'd1, 13'd1}},
        '{'{8'd0,   8'd255, 8'd0,   1'b1}, 1'b1, '{1'b0, 13'd0, 13'd0, 13'd0, 13'd1}},
        // red zero: blue wins before the purple band is looked at
        '{'{8'd1,   8'd0,   8'd0,   1'b1}, 1'b1, '{1'b1, 13'd1, 13'd0, 13'd0, 13'd1}},
        '{'{8'd0,   8'd0,   8'd1,   1'b1}, 1'b1, '{1'b0, 13'd0, 13'd1, 13'd0, 13'd1}},
        '{'{8'd255, 8'd0,   8'd255, 1'b1}, 1'b1, '{1'b1, 13'd0, 13'd0, 13'd1, 13'd1}},
        // ratio exactly on the band edge, green just under and on the mean
        '{'{8'd3,   8'd0,   8'd2,   1'b1}, 1'b0, NO_VOTE},
        '{'{8'd59,  8'd49,  8'd41,  1'b1}, 1'b0, NO_VOTE},
        '{'{8'd59,  8'd50,  8'd41,  1'b1}, 1'b0, NO_VOTE},
        // either side of the blue difference threshold
        '{'{8'd186, 8'd0,   8'd100, 1'b1}, 1'b0, NO_VOTE},
        '{'{8'd187, 8'd0,   8'd100, 1'b1}, 1'b0, NO_VOTE},
        // four-point contour, one of each class
        '{'{8'd200, 8'd50,  8'd10,  1'b0}, 1'b0, NO_VOTE},
        '{'{8'd10,  8'd50,  8'd200, 1'b0}, 1'b0, NO_VOTE},
        '{'{8'd100, 8'd10,  8'd100, 1'b0}, 1'b0, NO_VOTE},
        '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{1'b0, 13'd1, 13'd1, 13'd1, 13'd4}},
        '{'{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NO_VOTE},
        '{'{8'd255, 8'd255, 8'd0,   1'b1}, 1'b1, '{1'b1, 13'd2, 13'd0, 13'd0, 13'd2}},
        '{'{8'd0,   8'd128, 8'd255, 1'b0}, 1'b0, NO_VOTE},
        '{'{8'd200, 8'd255, 8'd100, 1'b1}, 1'b0, NO_VOTE}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [LEVEL_W-1:0]    blue_level  = '0;
    logic [LEVEL_W-1:0]    green_level = '0;
    logic [LEVEL_W-1:0]    red_level   = '0;
    logic                  last_point  = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  accepted;
    logic [TALLY_W-1:0]    blue_points;
    logic [TALLY_W-1:0]    red_points;
    logic [TALLY_W-1:0]    purple_points;
    logic [TALLY_W-1:0]    total_points;

    // Shadow of the block's settings and running counts
    logic [ENEMY_W-1:0]  enemy_sel    = ENEMY_RESET;
    logic [DIFF_W-1:0]   diff_ratio   = DIFF_RESET;
    logic [PURPLE_W-1:0] purple_limit = PURPLE_RESET;
    logic [VOTE_W-1:0]   vote_frac    = VOTE_RESET;
    logic [TALLY_W-1:0]  blue_run     = '0;
    logic [TALLY_W-1:0]  red_run      = '0;
    logic [TALLY_W-1:0]  purple_run   = '0;
    logic [TALLY_W-1:0]  point_run    = '0;

    vote_t pending_votes[$];
    int    errors         = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    hold_cycles    = 0;
    logic  hold_req       = 1'b0;
    int    cycles_run     = 0;

    contour_pixel_color_vote_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .blue_level    (blue_level),
        .green_level   (green_level),
        .red_level     (red_level),
        .last_point    (last_point),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .blue_points   (blue_points),
        .red_points    (red_points),
        .purple_points (purple_points),
        .total_points  (total_points)
    );

    always #6 clk = ~clk;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] t);
        return (t < TALLY_CAP) ? t + 1'b1 : TALLY_W'(TALLY_CAP);
    endfunction

    // Class one pixel; every ratio test is cross-multiplied
    function automatic pixel_class_t classify_pixel(input pixel_beat_t px);
        int unsigned b;
        int unsigned g;
        int unsigned r;
        int unsigned sum;
        int unsigned limit;
        b     = px.blue;
        g     = px.green;
        r     = px.red;
        sum   = b + r;
        limit = sum * diff_ratio;
        if (b > r && (b - r) * 256 > limit)
            return CLS_BLUE;
        if (r > b && (r - b) * 256 > limit)
            return CLS_RED;
        if (b * purple_limit > r * 256 && b * 256 < r * purple_limit && (sum >> 1) > g)
            return CLS_PURPLE;
        return CLS_NONE;
    endfunction

    // Count one point; on the closing point work out the vote and restart
    task automatic tally_point(input pixel_beat_t px, output bit closed, output vote_t vote);
        int unsigned need;
        int unsigned bl;
        int unsigned rd;
        int unsigned pu;
        case (classify_pixel(px))
            CLS_BLUE:   blue_run   = sat_inc(blue_run);
            CLS_RED:    red_run    = sat_inc(red_run);
            CLS_PURPLE: purple_run = sat_inc(purple_run);
            default:    ;
        endcase
        point_run = sat_inc(point_run);
        closed    = px.last;
        vote      = NO_VOTE;
        if (px.last) begin
            bl   = blue_run;
            rd   = red_run;
            pu   = purple_run;
            need = vote_frac * point_run;
            vote.accepted = (enemy_sel == ENEMY_BLUE && bl * 256 > need) ||
                            (enemy_sel == ENEMY_RED && rd * 256 > need) ||
                            (pu * 2560 > 9 * need);
            vote.blue   = blue_run;
            vote.red    = red_run;
            vote.purple = purple_run;
            vote.total  = point_run;
            blue_run    = '0;
            red_run     = '0;
            purple_run  = '0;
            point_run   = '0;
        end
    endtask

    // Offer one beat, hold it until taken, then predict
    task automatic send_point(input pixel_beat_t px, input bit typed, input vote_t want);
        bit    closed;
        vote_t vote;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        blue_level  <= px.blue;
        green_level <= px.green;
        red_level   <= px.red;
        last_point  <= px.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tally_point(px, closed, vote);
        if (closed)
            pending_votes.push_back(typed ? want : vote);
    endtask

    function automatic pixel_beat_t random_pixel(input pixel_class_t theme);
        pixel_beat_t px;
        int unsigned hi;
        int unsigned lo;
        int unsigned mean;
        px       = '0;
        px.green = $urandom_range(255);
        case (theme)
            CLS_BLUE: begin
                px.blue = $urandom_range(255, 64);
                px.red  = $urandom_range(px.blue / 3);
            end
            CLS_RED: begin
                px.red  = $urandom_range(255, 64);
                px.blue = $urandom_range(px.red / 3);
            end
            CLS_PURPLE: begin
                // near-equal channels with green under their mean
                px.red   = $urandom_range(255, 20);
                hi       = (px.red * 6 / 5 > 255) ? 255 : px.red * 6 / 5;
                lo       = px.red * 4 / 5;
                px.blue  = $urandom_range(hi, lo);
                mean     = (px.blue + px.red) >> 1;
                px.green = $urandom_range(mean - 1);
            end
            default: begin
                px.blue = $urandom_range(255);
                px.red  = $urandom_range(255);
                if ($urandom_range(3) == 0)
                    px.blue = $urandom_range(1) ? 8'd255 : 8'd0;
                if ($urandom_range(3) == 0)
                    px.red = $urandom_range(1) ? 8'd255 : 8'd0;
                if ($urandom_range(3) == 0)
                    px.green = $urandom_range(1) ? 8'd255 : 8'd0;
            end
        endcase
        return px;
    endfunction

    // One contour: mostly themed points, the rest noise
    task automatic send_contour(input pixel_class_t theme, input int len, input int noise_pct);
        pixel_beat_t px;
        for (int i = 0; i < len; i++) begin
            px      = random_pixel(($urandom_range(99) < noise_pct) ? CLS_NONE : theme);
            px.last = (i == len - 1);
            send_point(px, 1'b0, NO_VOTE);
        end
    endtask

    task automatic run_contours(input int n_items, input int max_len, input bit allow_long);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = (allow_long && $urandom_range(9) == 0) ? $urandom_range(60, 20)
                                                         : $urandom_range(max_len, 1);
            send_contour(pixel_class_t'($urandom_range(3)), len, 25);
            sent += len;
        end
    endtask

    // Drop valid, wait for every vote, then let the pipeline empty
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_votes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_ENEMY_COLOR:   enemy_sel    = val[ENEMY_W-1:0];
            CFG_DIFF_RATIO:    diff_ratio   = val[DIFF_W-1:0];
            CFG_PURPLE_RATIO:  purple_limit = val[PURPLE_W-1:0];
            CFG_VOTE_FRACTION: vote_frac    = val[VOTE_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] enemy,
                                  input logic [CFG_DATA_W-1:0] diff,
                                  input logic [CFG_DATA_W-1:0] purple,
                                  input logic [CFG_DATA_W-1:0] vote);
        write_reg(CFG_ENEMY_COLOR, enemy);
        write_reg(CFG_DIFF_RATIO, diff);
        write_reg(CFG_PURPLE_RATIO, purple);
        write_reg(CFG_VOTE_FRACTION, vote);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            IDLE_BOTH:     begin send_idle_pct = 17; recv_stall_pct = 17; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_vote();
        vote_t want;
        if (pending_votes.size() == 0) begin
            $display("%0t: result beat with nothing expected, accepted %0b total %0d",
                     $time, accepted, total_points);
            errors++;
        end else begin
            want = pending_votes.pop_front();
            check_field("accepted", want.accepted, accepted);
            check_field("blue_points", want.blue, blue_points);
            check_field("red_points", want.red, red_points);
            check_field("purple_points", want.purple, purple_points);
            check_field("total_points", want.total, total_points);
        end
    endtask

    // Take result beats; stall at random, or hold off for a long stretch on request
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_vote();
        if (hold_req && hold_cycles < HOLD_CYCLES) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            if (!hold_req)
                hold_cycles <= 0;
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Cycle limit
    initial begin
        while (cycles_run < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles_run++;
        end
        $display("contour_pixel_color_vote_core verification failed");
        $finish;
    end

    initial begin
        set_idle(IDLE_NONE);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset settings
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_point(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        quiesce();

        // Random contours over a run of settings, extremes first
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_settings(ENEMY_RED, 12'd0, 12'd256, 12'd0);
                1: apply_settings(ENEMY_SPARE, 12'd255, 12'd4095, 12'd255);
                2: apply_settings(ENEMY_NEITHER, 12'd77, 12'd200, 12'd128);
                3: apply_settings(ENEMY_BLUE, 12'd255, 12'd0, 12'd1);
                4: apply_settings(ENEMY_BLUE, 12'd26, 12'd512, 12'd200);
                default: apply_settings(CFG_DATA_W'($urandom_range(4095)),
                                        CFG_DATA_W'($urandom_range(4095)),
                                        CFG_DATA_W'($urandom_range(4095)),
                                        CFG_DATA_W'($urandom_range(4095)));
            endcase
            set_idle(idle_mode_t'(p % 4));
            run_contours(PHASE_ITEMS, 10, 1'b1);
            quiesce();

            // Hold the receiver off so the block backs up and stalls its input
            if (p == 4) begin
                set_idle(IDLE_NONE);
                hold_req <= 1'b1;
                run_contours(40, 2, 1'b0);
                hold_req <= 1'b0;
                quiesce();
            end
        end

        if (errors == 0)
            $display("contour_pixel_color_vote_core verification clean");
        else
            $display("contour_pixel_color_vote_core verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/cpcv_pkg.sv
design/cpcv_classify.sv
design/cpcv_queue.sv
design/cpcv_tally.sv
design/cpcv_vote.sv
design/contour_pixel_color_vote_core.sv
dv/tb_contour_pixel_color_vote_core.sv
